/* hdl/conv3_pkg.sv */
package conv3_pkg;

  // frame geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int FW_W         = 11;
  localparam int FH_W         = 13;
  localparam int ROW_W        = 13;
  localparam int HEIGHT_LIMIT = 4096;

  // pixel and coefficient formats
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 8;
  localparam int COEF_ROW_W     = 24;
  localparam int COEF_FRAC_BITS = 4;
  localparam int PROD_W         = 17;
  localparam int PSUM_W         = 19;
  localparam int SUM_W          = 21;

  // configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_TOP_COEFFS   = 3'd2,
    REG_MID_COEFFS   = 3'd3,
    REG_BOT_COEFFS   = 3'd4
  } cfg_reg_e;

  // one window column, index 0 is the top row
  typedef logic [2:0][PIX_W-1:0]  pix_col_t;
  typedef logic [2:0][COEF_W-1:0] coef_col_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // border masks seen by one window column
  typedef struct packed {
    logic top_en;
    logic bot_en;
    logic col_en;
  } cell_mask_t;

endpackage

/* hdl/conv3_cell.sv */
module conv3_cell import conv3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  pix_col_t   col_i,
  output pix_col_t   col_o,
  input  coef_col_t  coef_i,
  input  cell_mask_t mask_i,
  input  logic       calc_i,
  output psum_t      psum_o
);

  pix_col_t pix_q;
  psum_t    psum_q;
  psum_t    psum_d;

  // window column, shifted toward the left neighbor on every transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= col_i;
    end
  end

  assign col_o = pix_q;

  // masked column products and their sum
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic                     row_en;
    psum_d = '0;
    for (int k = 0; k < 3; k++) begin
      prod = $signed({1'b0, pix_q[k]}) * $signed(coef_i[k]);
      case (k)
        0:       row_en = mask_i.top_en;
        2:       row_en = mask_i.bot_en;
        default: row_en = 1'b1;
      endcase
      if (row_en && mask_i.col_en) begin
        psum_d = psum_d + PSUM_W'(prod);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_i) begin
      psum_q <= psum_d;
    end
  end

  assign psum_o = psum_q;

endmodule

/* hdl/conv3_line_buf.sv */
module conv3_line_buf import conv3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  logic             wr_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic [PIX_W-1:0] top_o,
  output logic [PIX_W-1:0] mid_o
);

  // each entry holds {older row, newer row} of one column
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd_q;
  logic               fwd_hit_q;
  logic [2*PIX_W-1:0] cur;
  logic [2*PIX_W-1:0] wdata;

  // entry of the transaction in flight, bypassing a write to the same column
  assign cur   = fwd_hit_q ? fwd_q : rd_q;
  assign top_o = cur[2*PIX_W-1:PIX_W];
  assign mid_o = cur[PIX_W-1:0];
  assign wdata = {cur[PIX_W-1:0], pix_i};

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_addr_i] <= wdata;
    end
    if (rd_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_i) begin
      fwd_hit_q <= wr_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

/* hdl/conv3x3_zero_pad_filter_top.sv */
// 3x3 convolution filter with zero padding for 8-bit grey pixels in raster
// order. One transaction is taken per clock when the output side keeps up;
// each carries a pixel or a drain tick. The result for raster position q comes
// with the transaction of position q + width + 1, so after the last pixel of a
// frame send width + 1 drain ticks; frame_last marks the final pixel. A result
// is built from the accepted transaction in this order: line buffer read at the
// accepting edge, then window shift, column products in the three window
// cells, and finally sum, shift by the fraction bits and saturation to
// 0..255 into the output register. The two previous
// rows sit in one 1024 x 16 memory with one read and one write port, which
// sets the one-transaction-per-cycle rate; a write to the column read in the
// same cycle is bypassed. The pipeline advances as a whole and halts only
// while a result waits at the output. Coefficients are signed Q3.4 bytes,
// left column in bits 7:0. Width or height 0 counts as 1 and values beyond the limits
// (1024 columns, 4096 rows) saturate. Write configuration only while idle.
module conv3x3_zero_pad_filter_top import conv3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_ROW_W-1:0] cfg_data_i,
  // input pixels
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  // filtered pixels
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  frame_last_o
);

  // configuration registers
  logic [FW_W-1:0]       frame_width_q;
  logic [FH_W-1:0]       frame_height_q;
  logic [COEF_ROW_W-1:0] top_coeffs_q;
  logic [COEF_ROW_W-1:0] mid_coeffs_q;
  logic [COEF_ROW_W-1:0] bot_coeffs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(512);
      frame_height_q <= FH_W'(512);
      top_coeffs_q   <= COEF_ROW_W'(24'hF000F0);
      mid_coeffs_q   <= COEF_ROW_W'(24'h004000);
      bot_coeffs_q   <= COEF_ROW_W'(24'hF000F0);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        REG_TOP_COEFFS:   top_coeffs_q   <= cfg_data_i;
        REG_MID_COEFFS:   mid_coeffs_q   <= cfg_data_i;
        REG_BOT_COEFFS:   bot_coeffs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and input handshake
  logic out_valid_q;
  logic adv;
  logic accept;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // effective frame size
  logic [FW_W-1:0] w;
  logic [FH_W-1:0] h;

  always_comb begin
    if (frame_width_q == '0) begin
      w = FW_W'(1);
    end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
      w = FW_W'(MAX_WIDTH);
    end else begin
      w = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h = FH_W'(1);
    end else if (frame_height_q > FH_W'(HEIGHT_LIMIT)) begin
      h = FH_W'(HEIGHT_LIMIT);
    end else begin
      h = frame_height_q;
    end
  end

  // raster position and border decisions for the incoming transaction
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] colr;
  logic [ROW_W-1:0] rowr;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic             has_out;
  logic             last;
  logic             top_en, bot_en, left_en, right_en;
  logic [FW_W-1:0]  col_inc;
  logic [FH_W-1:0]  h_plus1;
  logic             restart;

  always_comb begin
    h_plus1 = h + FH_W'(1);
    restart = (FW_W'(col_q) >= w) || (row_q > h_plus1) ||
              ((row_q == h_plus1) && (col_q != '0));
    colr    = restart ? '0 : col_q;
    rowr    = restart ? '0 : row_q;
    has_out = !((rowr == '0) || ((rowr == ROW_W'(1)) && (colr == '0)));
    if (colr == '0) begin
      c = COL_W'(w - FW_W'(1));
      r = rowr - ROW_W'(2);
    end else begin
      c = colr - COL_W'(1);
      r = rowr - ROW_W'(1);
    end
    top_en   = (r != '0);
    bot_en   = ((ROW_W+1)'(r) + (ROW_W+1)'(1)) < (ROW_W+1)'(h);
    left_en  = (c != '0);
    right_en = (FW_W'(c) + FW_W'(1)) < w;
    last     = has_out && (r == (h - FH_W'(1))) && (FW_W'(c) == (w - FW_W'(1)));
    col_inc  = FW_W'(colr) + FW_W'(1);
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w) begin
      col_d = '0;
      row_d = rowr + ROW_W'(1);
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = rowr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line buffer data arrives
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_out_q;
  logic             s1_last_q;
  logic [3:0]       s1_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= action_i ? '0 : pixel_in_i;
      s1_col_q  <= colr;
      s1_out_q  <= has_out;
      s1_last_q <= last;
      s1_mask_q <= {top_en, bot_en, left_en, right_en};
    end
  end

  logic [PIX_W-1:0] lb_top;
  logic [PIX_W-1:0] lb_mid;
  logic             shift;

  assign shift = s1_valid_q && adv;

  conv3_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (accept),
    .rd_addr_i (colr),
    .wr_i      (shift),
    .wr_addr_i (s1_col_q),
    .pix_i     (s1_pix_q),
    .top_o     (lb_top),
    .mid_o     (lb_mid)
  );

  // stage 2: window holds the neighborhood, cells form column products
  logic       s2_valid_q;
  logic       s2_last_q;
  logic [3:0] s2_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_last_q <= s1_last_q;
      s2_mask_q <= s1_mask_q;
    end
  end

  // new column enters the right cell, top row first
  pix_col_t  new_col;
  pix_col_t  win_right;
  pix_col_t  win_centre;
  coef_col_t coef_col [3];
  cell_mask_t mask_left, mask_centre, mask_right;
  psum_t     psum_left, psum_centre, psum_right;

  assign new_col = {s1_pix_q, lb_mid, lb_top};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef_col[j] = {bot_coeffs_q[COEF_W*j +: COEF_W],
                     mid_coeffs_q[COEF_W*j +: COEF_W],
                     top_coeffs_q[COEF_W*j +: COEF_W]};
    end
  end

  assign mask_left   = '{top_en: s2_mask_q[3], bot_en: s2_mask_q[2], col_en: s2_mask_q[1]};
  assign mask_centre = '{top_en: s2_mask_q[3], bot_en: s2_mask_q[2], col_en: 1'b1};
  assign mask_right  = '{top_en: s2_mask_q[3], bot_en: s2_mask_q[2], col_en: s2_mask_q[0]};

  conv3_cell u_cell_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (new_col),
    .col_o   (win_right),
    .coef_i  (coef_col[2]),
    .mask_i  (mask_right),
    .calc_i  (adv),
    .psum_o  (psum_right)
  );

  conv3_cell u_cell_centre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (win_right),
    .col_o   (win_centre),
    .coef_i  (coef_col[1]),
    .mask_i  (mask_centre),
    .calc_i  (adv),
    .psum_o  (psum_centre)
  );

  conv3_cell u_cell_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (win_centre),
    .col_o   (),
    .coef_i  (coef_col[0]),
    .mask_i  (mask_left),
    .calc_i  (adv),
    .psum_o  (psum_left)
  );

  // stage 3: column sums are ready
  logic s3_valid_q;
  logic s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_last_q <= s2_last_q;
    end
  end

  // total, drop fraction bits and clip to the pixel range
  sum_t             total;
  sum_t             scaled;
  logic [PIX_W-1:0] res;

  always_comb begin
    total  = SUM_W'(psum_left) + SUM_W'(psum_centre) + SUM_W'(psum_right);
    scaled = total >>> COEF_FRAC_BITS;
    if (total <= 0) begin
      res = '0;
    end else if (scaled > SUM_W'((1 << PIX_W) - 1)) begin
      res = '1;
    end else begin
      res = scaled[PIX_W-1:0];
    end
  end

  // output register
  logic [PIX_W-1:0] pixel_out_q;
  logic             frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_q  <= res;
      frame_last_q <= s3_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

endmodule
